// ===== design/erafp_pkg.sv =====
// ----------------------------------------------------------------------------
// erafp_pkg
// Types and constants shared by the escaped API frame parser.
// ----------------------------------------------------------------------------
`default_nettype none

package erafp_pkg;

  localparam logic [7:0] START_BYTE = 8'h7E;
  localparam logic [7:0] ESC_BYTE   = 8'h7D;
  localparam logic [7:0] ESC_XOR    = 8'h20;

  localparam logic [7:0] TYPE_RX    = 8'h90;
  localparam logic [7:0] TYPE_MODEM = 8'h8A;
  localparam logic [7:0] TYPE_TX    = 8'h8B;

  localparam logic [15:0] TX_FRAME_LEN    = 16'h0007;
  localparam logic [15:0] MODEM_FRAME_LEN = 16'h0002;

  localparam logic [7:0] MDM_HW_RESET  = 8'h00;
  localparam logic [7:0] MDM_WDT_RESET = 8'h01;
  localparam logic [7:0] MDM_SLEEP     = 8'h0C;
  localparam logic [7:0] MDM_WAKE      = 8'h0B;

  localparam logic [7:0] SUM_BASE = 8'hFF;

  typedef enum logic [3:0] {
    ST_HUNT    = 4'd0,
    ST_LEN_HI  = 4'd1,
    ST_LEN_LO  = 4'd2,
    ST_TYPE    = 4'd3,
    ST_RX_HDR  = 4'd4,
    ST_TX_HDR  = 4'd5,
    ST_PAYLOAD = 4'd6,
    ST_RETRY   = 4'd7,
    ST_DELIV   = 4'd8,
    ST_DISC    = 4'd9,
    ST_CHECK   = 4'd10,
    ST_MODEM   = 4'd11
  } parse_state_t;

  typedef enum logic [1:0] {
    KIND_NONE  = 2'd0,
    KIND_RX    = 2'd1,
    KIND_MODEM = 2'd2,
    KIND_TX    = 2'd3
  } frame_kind_t;

  typedef enum logic [3:0] {
    EV_PAYLOAD      = 4'd0,
    EV_RX_OK        = 4'd1,
    EV_HW_RESET     = 4'd2,
    EV_WDT_RESET    = 4'd3,
    EV_SLEEP        = 4'd4,
    EV_WAKE         = 4'd5,
    EV_BAD_MODEM    = 4'd6,
    EV_TX_OK        = 4'd7,
    EV_TX_FAIL      = 4'd8,
    EV_INCOMPLETE   = 4'd9,
    EV_BAD_TXLEN    = 4'd10,
    EV_BAD_TYPE     = 4'd11,
    EV_BAD_MODEMLEN = 4'd12,
    EV_BAD_SUM      = 4'd13
  } event_code_t;

  typedef struct packed {
    parse_state_t state;
    logic [15:0]  frame_length;
    logic [15:0]  length_count;
    logic [4:0]   header_count;
    logic [7:0]   running_sum;
    logic         escape_pending;
    frame_kind_t  frame_kind;
    logic [7:0]   modem_code;
    logic [7:0]   saved_retries;
    logic [7:0]   saved_delivery;
    logic [7:0]   saved_discovery;
  } parse_regs_t;

  localparam parse_regs_t PARSE_CLEAR = '{
    state:           ST_HUNT,
    frame_length:    16'h0000,
    length_count:    16'h0000,
    header_count:    5'd0,
    running_sum:     8'h00,
    escape_pending:  1'b0,
    frame_kind:      KIND_NONE,
    modem_code:      8'h00,
    saved_retries:   8'h00,
    saved_delivery:  8'h00,
    saved_discovery: 8'h00
  };

  typedef struct packed {
    event_code_t code;
    logic [7:0]  data_value;
    logic [7:0]  retry_count;
    logic [7:0]  delivery_status;
    logic [7:0]  discovery_status;
  } event_t;

endpackage

`default_nettype wire

// ===== design/erafp_ifs.sv =====
// ----------------------------------------------------------------------------
// erafp channel interfaces
// Valid/ready channels for raw link bytes and for parser events.
// ----------------------------------------------------------------------------
`default_nettype none

interface erafp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface erafp_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] event_code;
  logic [7:0] data_value;
  logic [7:0] retry_count;
  logic [7:0] delivery_status;
  logic [7:0] discovery_status;

  modport source (output valid, output event_code, output data_value, output retry_count,
                  output delivery_status, output discovery_status, input ready);
  modport sink   (input valid, input event_code, input data_value, input retry_count,
                  input delivery_status, input discovery_status, output ready);
endinterface

`default_nettype wire

// ===== design/erafp_step.sv =====
// ----------------------------------------------------------------------------
// erafp_step
// Next-state and event decode for one received byte of an escaped frame.
// ----------------------------------------------------------------------------
`default_nettype none

module erafp_step #(
  parameter int unsigned RX_HEADER_BYTES = 15,
  parameter int unsigned TX_HEADER_BYTES = 7
) (
  input  erafp_pkg::parse_regs_t cur,
  input  logic [7:0]             rx_byte,
  output erafp_pkg::parse_regs_t nxt,
  output logic                   ev_vld,
  output erafp_pkg::event_t      ev
);
  import erafp_pkg::*;

  localparam logic [4:0] RX_HDR_CNT = 5'(RX_HEADER_BYTES);
  localparam logic [4:0] TX_HDR_CNT = 5'(TX_HEADER_BYTES);

  logic [7:0]  dbyte;
  logic [4:0]  hc_inc;
  logic [15:0] lc_inc;
  logic [7:0]  sum_inc;

  assign dbyte   = cur.escape_pending ? (rx_byte ^ ESC_XOR) : rx_byte;
  assign hc_inc  = cur.header_count + 5'd1;
  assign lc_inc  = cur.length_count + 16'd1;
  assign sum_inc = cur.running_sum + dbyte;

  always_comb begin
    nxt    = cur;
    ev_vld = 1'b0;
    ev     = '{code: EV_PAYLOAD, default: '0};

    if (cur.state == ST_HUNT) begin
      if (rx_byte == START_BYTE) begin
        nxt.state        = ST_LEN_HI;
        nxt.header_count = 5'd1;
      end
    end else if (!cur.escape_pending && rx_byte == ESC_BYTE) begin
      nxt.escape_pending = 1'b1;
    end else if (!cur.escape_pending && rx_byte == START_BYTE) begin
      // start byte inside a frame: report and resync on it
      nxt              = PARSE_CLEAR;
      nxt.state        = ST_LEN_HI;
      nxt.header_count = 5'd1;
      ev_vld           = 1'b1;
      ev.code          = EV_INCOMPLETE;
    end else begin
      nxt.escape_pending = 1'b0;
      unique case (cur.state)
        ST_LEN_HI: begin
          nxt.frame_length = {dbyte, 8'h00};
          nxt.header_count = hc_inc;
          nxt.state        = ST_LEN_LO;
        end
        ST_LEN_LO: begin
          nxt.frame_length = cur.frame_length | {8'h00, dbyte};
          nxt.header_count = hc_inc;
          nxt.state        = ST_TYPE;
        end
        ST_TYPE: begin
          nxt.header_count = hc_inc;
          nxt.length_count = lc_inc;
          nxt.running_sum  = sum_inc;
          if (dbyte == TYPE_RX) begin
            nxt.frame_kind = KIND_RX;
            nxt.state      = (hc_inc == RX_HDR_CNT) ? ST_PAYLOAD : ST_RX_HDR;
          end else if (dbyte == TYPE_MODEM) begin
            nxt.frame_kind = KIND_MODEM;
            nxt.state      = ST_MODEM;
          end else if (dbyte == TYPE_TX) begin
            if (cur.frame_length != TX_FRAME_LEN) begin
              nxt     = PARSE_CLEAR;
              ev_vld  = 1'b1;
              ev.code = EV_BAD_TXLEN;
            end else begin
              nxt.frame_kind = KIND_TX;
              nxt.state      = (hc_inc == TX_HDR_CNT) ? ST_RETRY : ST_TX_HDR;
            end
          end else begin
            nxt           = PARSE_CLEAR;
            ev_vld        = 1'b1;
            ev.code       = EV_BAD_TYPE;
            ev.data_value = dbyte;
          end
        end
        ST_MODEM: begin
          if (cur.frame_length != MODEM_FRAME_LEN) begin
            nxt     = PARSE_CLEAR;
            ev_vld  = 1'b1;
            ev.code = EV_BAD_MODEMLEN;
          end else begin
            nxt.header_count = hc_inc;
            nxt.length_count = lc_inc;
            nxt.running_sum  = sum_inc;
            nxt.modem_code   = dbyte;
            nxt.state        = ST_CHECK;
          end
        end
        ST_RX_HDR: begin
          nxt.header_count = hc_inc;
          nxt.length_count = lc_inc;
          nxt.running_sum  = sum_inc;
          if (hc_inc == RX_HDR_CNT) begin
            nxt.state = ST_PAYLOAD;
          end
        end
        ST_TX_HDR: begin
          nxt.header_count = hc_inc;
          nxt.length_count = lc_inc;
          nxt.running_sum  = sum_inc;
          if (hc_inc == TX_HDR_CNT) begin
            nxt.state = ST_RETRY;
          end
        end
        ST_PAYLOAD: begin
          nxt.header_count = hc_inc;
          nxt.length_count = lc_inc;
          nxt.running_sum  = sum_inc;
          if (lc_inc == cur.frame_length) begin
            nxt.state = ST_CHECK;
          end
          ev_vld        = 1'b1;
          ev.code       = EV_PAYLOAD;
          ev.data_value = dbyte;
        end
        ST_RETRY: begin
          nxt.header_count  = hc_inc;
          nxt.length_count  = lc_inc;
          nxt.running_sum   = sum_inc;
          nxt.saved_retries = dbyte;
          nxt.state         = ST_DELIV;
        end
        ST_DELIV: begin
          nxt.header_count   = hc_inc;
          nxt.length_count   = lc_inc;
          nxt.running_sum    = sum_inc;
          nxt.saved_delivery = dbyte;
          nxt.state          = ST_DISC;
        end
        ST_DISC: begin
          nxt.header_count    = hc_inc;
          nxt.length_count    = lc_inc;
          nxt.running_sum     = sum_inc;
          nxt.saved_discovery = dbyte;
          nxt.state           = ST_CHECK;
        end
        ST_CHECK: begin
          nxt = PARSE_CLEAR;
          if ((SUM_BASE - cur.running_sum) == dbyte) begin
            unique case (cur.frame_kind)
              KIND_RX: begin
                ev_vld  = 1'b1;
                ev.code = EV_RX_OK;
              end
              KIND_MODEM: begin
                ev_vld = 1'b1;
                unique case (cur.modem_code)
                  MDM_HW_RESET:  ev.code = EV_HW_RESET;
                  MDM_WDT_RESET: ev.code = EV_WDT_RESET;
                  MDM_SLEEP:     ev.code = EV_SLEEP;
                  MDM_WAKE:      ev.code = EV_WAKE;
                  default: begin
                    ev.code       = EV_BAD_MODEM;
                    ev.data_value = cur.modem_code;
                  end
                endcase
              end
              KIND_TX: begin
                ev_vld              = 1'b1;
                ev.code             = (cur.saved_delivery == 8'h00) ? EV_TX_OK : EV_TX_FAIL;
                ev.retry_count      = cur.saved_retries;
                ev.delivery_status  = cur.saved_delivery;
                ev.discovery_status = cur.saved_discovery;
              end
              default: ev_vld = 1'b0;
            endcase
          end else begin
            ev_vld  = 1'b1;
            ev.code = EV_BAD_SUM;
          end
        end
        default: nxt = PARSE_CLEAR;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== design/escaped_radio_api_frame_parser_core.sv =====
// ----------------------------------------------------------------------------
// escaped_radio_api_frame_parser_core
// Byte-wide parser for escaped (API mode 2) radio frames, emitting events.
// ----------------------------------------------------------------------------
// Takes one raw link byte per request and returns at most one event per byte:
// a streamed payload byte, a decoded receive/modem/transmit status at the
// checksum, or an error (incomplete frame, bad length, bad type, bad sum).
// A byte is taken every clock cycle while the event register is empty or
// being drained; its event, if any, appears in that register in the next cycle.
// The whole decode of a byte is one pass through the parser state and an
// 8-bit checksum adder. Nothing is buffered beyond the single event register.
// ----------------------------------------------------------------------------
`default_nettype none

module escaped_radio_api_frame_parser_core #(
  parameter int unsigned RX_HEADER_BYTES = 15,
  parameter int unsigned TX_HEADER_BYTES = 7
) (
  input  logic        clk,
  input  logic        rst_n,
  erafp_in_if.sink    in_ch,
  erafp_out_if.source out_ch
);
  import erafp_pkg::*;

  parse_regs_t cur_r;
  parse_regs_t cur_nxt;
  event_t      out_r;
  logic        out_valid_r;
  logic        out_valid_nxt;
  logic        ev_vld;
  event_t      ev;
  logic        in_acc;

  erafp_step #(
    .RX_HEADER_BYTES (RX_HEADER_BYTES),
    .TX_HEADER_BYTES (TX_HEADER_BYTES)
  ) u_step (
    .cur     (cur_r),
    .rx_byte (in_ch.rx_byte),
    .nxt     (cur_nxt),
    .ev_vld  (ev_vld),
    .ev      (ev)
  );

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_acc      = in_ch.valid && in_ch.ready;

  always_comb begin
    if (in_acc) begin
      out_valid_nxt = ev_vld;
    end else begin
      out_valid_nxt = out_valid_r && !out_ch.ready;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_r       <= PARSE_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (in_acc) begin
        cur_r <= cur_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && ev_vld) begin
      out_r <= ev;
    end
  end

  assign out_ch.valid            = out_valid_r;
  assign out_ch.event_code       = out_r.code;
  assign out_ch.data_value       = out_r.data_value;
  assign out_ch.retry_count      = out_r.retry_count;
  assign out_ch.delivery_status  = out_r.delivery_status;
  assign out_ch.discovery_status = out_r.discovery_status;

  // an accepted byte that raises an event must show it next cycle
  a_event_lands: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && ev_vld |=> out_ch.valid)
    else $error("event from accepted byte not presented");

  // no escape can be pending while hunting for a start byte
  a_hunt_no_esc: assert property (@(posedge clk) disable iff (!rst_n)
    cur_r.state == ST_HUNT |-> !cur_r.escape_pending)
    else $error("escape pending in hunt state");

  // transmit status bytes are only carried by transmit status events
  a_tx_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.event_code != EV_TX_OK && out_ch.event_code != EV_TX_FAIL
    |-> out_ch.retry_count == 8'h00 && out_ch.delivery_status == 8'h00
        && out_ch.discovery_status == 8'h00)
    else $error("transmit status fields set on non-transmit event");

endmodule

`default_nettype wire

// ===== dv/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Testbench for the escaped API frame parser core.
// ----------------------------------------------------------------------------
// A short table of hand-picked link bytes comes first: hunt bytes, premature
// start, escaped status, and each error event but bad modem. Random frames
// follow: receive, transmit status and modem status with random escaping and
// content, mixed with truncated frames, short receive lengths, bad types, bad
// lengths, bad sums and line noise. A shadow parser predicts every event, and
// the monitor compares each delivered event field by field, oldest first.
// ----------------------------------------------------------------------------

module tb;
  import erafp_pkg::*;

  localparam int unsigned RX_HDR_LEN   = 15;
  localparam int unsigned TX_HDR_LEN   = 7;
  localparam int          RANDOM_ITEMS = 1550;
  localparam int          HOLD_CYCLES  = 300;
  localparam int          HOLD_FRAME   = 25;
  localparam int          PAUSE_FRAME  = 60;
  localparam longint      TIMEOUT_NS   = 1_000_000;

  typedef struct packed {
    logic [7:0]  rx_byte;
    logic        typed;
    event_code_t code;
    logic [7:0]  data;
  } seq_row_t;

  // typed rows carry their event literally, the rest go through the shadow parser
  localparam seq_row_t DIRECTED_ROWS [28] = '{
    '{8'h00, 1'b0, EV_PAYLOAD,      8'h00},
    '{8'h7E, 1'b0, EV_PAYLOAD,      8'h00},
    '{8'h7E, 1'b1, EV_INCOMPLETE,   8'h00},
    '{8'h00, 1'b0, EV_PAYLOAD,      8'h00},
    '{8'h02, 1'b0, EV_PAYLOAD,      8'h00},
    '{8'h8A, 1'b0, EV_PAYLOAD,      8'h00},
    '{8'h7D, 1'b0, EV_PAYLOAD,      8'h00},
    '{8'h2C, 1'b0, EV_PAYLOAD,      8'h00},
    '{8'h69, 1'b1, EV_SLEEP,        8'h00},
    '{8'h7E, 1'b0, EV_PAYLOAD,      8'h00},
    '{8'h00, 1'b0, EV_PAYLOAD,      8'h00},
    '{8'h03, 1'b0, EV_PAYLOAD,      8'h00},
    '{8'h8A, 1'b0, EV_PAYLOAD,      8'h00},
    '{8'hFF, 1'b1, EV_BAD_MODEMLEN, 8'h00},
    '{8'h7E, 1'b0, EV_PAYLOAD,      8'h00},
    '{8'h00, 1'b0, EV_PAYLOAD,      8'h00},
    '{8'h07, 1'b0, EV_PAYLOAD,      8'h00},
    '{8'h55, 1'b1, EV_BAD_TYPE,     8'h55},
    '{8'h7E, 1'b0, EV_PAYLOAD,      8'h00},
    '{8'h00, 1'b0, EV_PAYLOAD,      8'h00},
    '{8'h05, 1'b0, EV_PAYLOAD,      8'h00},
    '{8'h8B, 1'b1, EV_BAD_TXLEN,    8'h00},
    '{8'h7E, 1'b0, EV_PAYLOAD,      8'h00},
    '{8'h00, 1'b0, EV_PAYLOAD,      8'h00},
    '{8'h02, 1'b0, EV_PAYLOAD,      8'h00},
    '{8'h8A, 1'b0, EV_PAYLOAD,      8'h00},
    '{8'hFF, 1'b0, EV_PAYLOAD,      8'h00},
    '{8'h00, 1'b1, EV_BAD_SUM,      8'h00}
  };

  logic clk;
  logic rst_n;

  erafp_in_if  in_ch ();
  erafp_out_if out_ch ();

  escaped_radio_api_frame_parser_core #(
    .RX_HEADER_BYTES(RX_HDR_LEN),
    .TX_HEADER_BYTES(TX_HDR_LEN)
  ) i_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch.sink),
    .out_ch(out_ch.source)
  );

  parse_regs_t shadow;
  event_t      pending_events[$];
  logic [7:0]  frame_q[$];
  logic [7:0]  frame_sum;
  int          burst_left;
  bit          hold_req;
  int          mismatches;
  int          n_checked;
  int          n_bytes;
  int          n_rx, n_tx, n_modem, n_broken;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("timeout: %0d events still outstanding", pending_events.size());
    $display("end of test: mismatches");
    $finish;
  end

  task automatic flag_mismatch(input string what, input logic [7:0] got, input logic [7:0] want);
    $display("MISMATCH %s: got %02h want %02h at %0t", what, got, want, $realtime);
    mismatches++;
  endtask

  // ---------------- shadow parser ----------------

  function automatic void count_byte(input logic [7:0] b);
    shadow.header_count = shadow.header_count + 5'd1;
    shadow.length_count = shadow.length_count + 16'd1;
    shadow.running_sum  = shadow.running_sum + b;
  endfunction

  function automatic void close_frame(output bit fired, output event_t ev);
    fired = 1'b1;
    ev    = '0;
    case (shadow.frame_kind)
      KIND_RX: ev.code = EV_RX_OK;
      KIND_MODEM: begin
        case (shadow.modem_code)
          MDM_HW_RESET:  ev.code = EV_HW_RESET;
          MDM_WDT_RESET: ev.code = EV_WDT_RESET;
          MDM_SLEEP:     ev.code = EV_SLEEP;
          MDM_WAKE:      ev.code = EV_WAKE;
          default: begin
            ev.code       = EV_BAD_MODEM;
            ev.data_value = shadow.modem_code;
          end
        endcase
      end
      KIND_TX: begin
        if (shadow.saved_delivery == 8'h00) ev.code = EV_TX_OK;
        else ev.code = EV_TX_FAIL;
        ev.retry_count      = shadow.saved_retries;
        ev.delivery_status  = shadow.saved_delivery;
        ev.discovery_status = shadow.saved_discovery;
      end
      default: fired = 1'b0;
    endcase
    shadow = PARSE_CLEAR;
  endfunction

  function automatic void predict_event(input logic [7:0] raw, output bit fired,
                                        output event_t ev);
    logic [7:0] b;
    b     = raw;
    fired = 1'b0;
    ev    = '0;
    if (shadow.state == ST_HUNT) begin
      if (b == START_BYTE) begin
        shadow.state        = ST_LEN_HI;
        shadow.header_count = 5'd1;
      end
      return;
    end
    if (!shadow.escape_pending && b == ESC_BYTE) begin
      shadow.escape_pending = 1'b1;
      return;
    end
    // unescaped start inside a frame: report and begin a fresh frame
    if (!shadow.escape_pending && b == START_BYTE) begin
      shadow              = PARSE_CLEAR;
      shadow.state        = ST_LEN_HI;
      shadow.header_count = 5'd1;
      fired               = 1'b1;
      ev.code             = EV_INCOMPLETE;
      return;
    end
    if (shadow.escape_pending) begin
      b                     = b ^ ESC_XOR;
      shadow.escape_pending = 1'b0;
    end
    case (shadow.state)
      ST_LEN_HI: begin
        shadow.frame_length = {b, 8'h00};
        shadow.header_count = shadow.header_count + 5'd1;
        shadow.state        = ST_LEN_LO;
      end
      ST_LEN_LO: begin
        shadow.frame_length[7:0] = b;
        shadow.header_count      = shadow.header_count + 5'd1;
        shadow.state             = ST_TYPE;
      end
      ST_TYPE: begin
        count_byte(b);
        if (b == TYPE_RX) begin
          shadow.frame_kind = KIND_RX;
          if (shadow.header_count == RX_HDR_LEN) shadow.state = ST_PAYLOAD;
          else shadow.state = ST_RX_HDR;
        end else if (b == TYPE_MODEM) begin
          shadow.frame_kind = KIND_MODEM;
          shadow.state      = ST_MODEM;
        end else if (b == TYPE_TX) begin
          if (shadow.frame_length != TX_FRAME_LEN) begin
            shadow  = PARSE_CLEAR;
            fired   = 1'b1;
            ev.code = EV_BAD_TXLEN;
          end else begin
            shadow.frame_kind = KIND_TX;
            if (shadow.header_count == TX_HDR_LEN) shadow.state = ST_RETRY;
            else shadow.state = ST_TX_HDR;
          end
        end else begin
          shadow        = PARSE_CLEAR;
          fired         = 1'b1;
          ev.code       = EV_BAD_TYPE;
          ev.data_value = b;
        end
      end
      ST_MODEM: begin
        count_byte(b);
        if (shadow.frame_length != MODEM_FRAME_LEN) begin
          shadow  = PARSE_CLEAR;
          fired   = 1'b1;
          ev.code = EV_BAD_MODEMLEN;
        end else begin
          shadow.modem_code = b;
          shadow.state      = ST_CHECK;
        end
      end
      ST_RX_HDR: begin
        count_byte(b);
        if (shadow.header_count == RX_HDR_LEN) shadow.state = ST_PAYLOAD;
      end
      ST_TX_HDR: begin
        count_byte(b);
        if (shadow.header_count == TX_HDR_LEN) shadow.state = ST_RETRY;
      end
      ST_PAYLOAD: begin
        count_byte(b);
        if (shadow.length_count == shadow.frame_length) shadow.state = ST_CHECK;
        fired         = 1'b1;
        ev.code       = EV_PAYLOAD;
        ev.data_value = b;
      end
      ST_RETRY: begin
        count_byte(b);
        shadow.saved_retries = b;
        shadow.state         = ST_DELIV;
      end
      ST_DELIV: begin
        count_byte(b);
        shadow.saved_delivery = b;
        shadow.state          = ST_DISC;
      end
      ST_DISC: begin
        count_byte(b);
        shadow.saved_discovery = b;
        shadow.state           = ST_CHECK;
      end
      ST_CHECK: begin
        if (8'(SUM_BASE - shadow.running_sum) == b) begin
          close_frame(fired, ev);
        end else begin
          shadow  = PARSE_CLEAR;
          fired   = 1'b1;
          ev.code = EV_BAD_SUM;
        end
      end
      default: shadow = PARSE_CLEAR;
    endcase
  endfunction

  // ---------------- frame building ----------------

  function automatic void queue_raw(input logic [7:0] b);
    frame_q = {frame_q, b};
  endfunction

  function automatic logic [7:0] pick_byte();
    logic [7:0] specials [6];
    specials = '{START_BYTE, ESC_BYTE, 8'h00, 8'hFF, 8'h11, 8'h13};
    if ($urandom_range(0, 99) < 15) return specials[$urandom_range(0, 5)];
    return 8'($urandom_range(0, 255));
  endfunction

  // escape the reserved bytes, and now and then an ordinary one
  function automatic void put_coded(input logic [7:0] b);
    if (b == START_BYTE || b == ESC_BYTE || $urandom_range(0, 15) == 0) begin
      queue_raw(ESC_BYTE);
      queue_raw(b ^ ESC_XOR);
    end else begin
      queue_raw(b);
    end
  endfunction

  function automatic void put_body(input logic [7:0] b);
    frame_sum = frame_sum + b;
    put_coded(b);
  endfunction

  function automatic void put_header(input logic [15:0] len);
    frame_sum = 8'h00;
    queue_raw(START_BYTE);
    put_coded(len[15:8]);
    put_coded(len[7:0]);
  endfunction

  function automatic void put_check(input bit good_sum);
    logic [7:0] c;
    c = SUM_BASE - frame_sum;
    if (!good_sum) c = c + 8'($urandom_range(1, 255));
    put_coded(c);
  endfunction

  function automatic void build_rx(input int plen, input bit good_len, input bit good_sum);
    logic [15:0] len;
    if (good_len) len = 16'(RX_HDR_LEN - 3 + plen);
    else len = 16'($urandom_range(0, RX_HDR_LEN - 3));
    put_header(len);
    put_body(TYPE_RX);
    repeat (RX_HDR_LEN - 4) put_body(pick_byte());
    repeat (plen) put_body(pick_byte());
    put_check(good_sum);
  endfunction

  function automatic void build_tx(input bit good_sum);
    put_header(TX_FRAME_LEN);
    put_body(TYPE_TX);
    repeat (TX_HDR_LEN - 4) put_body(pick_byte());
    put_body(pick_byte());
    put_body($urandom_range(0, 1) ? 8'h00 : pick_byte());
    put_body(pick_byte());
    put_check(good_sum);
  endfunction

  function automatic void build_modem(input bit good_sum);
    logic [7:0] code;
    case ($urandom_range(0, 5))
      0: code = MDM_HW_RESET;
      1: code = MDM_WDT_RESET;
      2: code = MDM_SLEEP;
      3: code = MDM_WAKE;
      default: code = pick_byte();
    endcase
    put_header(MODEM_FRAME_LEN);
    put_body(TYPE_MODEM);
    put_body(code);
    put_check(good_sum);
  endfunction

  function automatic int pick_payload_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(1, 8);
    if (r < 95) return $urandom_range(9, 24);
    return $urandom_range(25, 60);
  endfunction

  function automatic void build_good_frame(input bit good_sum);
    case ($urandom_range(0, 2))
      0: build_rx(pick_payload_len(), 1'b1, good_sum);
      1: build_tx(good_sum);
      default: build_modem(good_sum);
    endcase
  endfunction

  function automatic void build_any_frame();
    int          r;
    int          keep;
    logic [7:0]  t;
    logic [15:0] len;
    r = $urandom_range(0, 99);
    if (r < 30) begin
      build_rx(pick_payload_len(), 1'b1, $urandom_range(0, 9) != 0);
      n_rx++;
    end else if (r < 45) begin
      build_tx($urandom_range(0, 9) != 0);
      n_tx++;
    end else if (r < 60) begin
      build_modem($urandom_range(0, 9) != 0);
      n_modem++;
    end else begin
      n_broken++;
      if (r < 65) begin
        // length too short: payload runs on until the next start
        build_rx($urandom_range(1, 10), 1'b0, 1'b1);
      end else if (r < 73) begin
        build_good_frame(1'b1);
        keep = $urandom_range(1, frame_q.size() - 1);
        while (frame_q.size() > keep) void'(frame_q.pop_back());
      end else if (r < 79) begin
        repeat ($urandom_range(1, 6)) queue_raw(pick_byte());
      end else if (r < 84) begin
        do t = pick_byte();
        while (t == TYPE_RX || t == TYPE_MODEM || t == TYPE_TX);
        put_header(16'($urandom_range(0, 16'hFFFF)));
        put_body(t);
      end else if (r < 89) begin
        do len = 16'($urandom_range(0, 16'hFFFF));
        while (len == TX_FRAME_LEN);
        put_header(len);
        put_body(TYPE_TX);
      end else if (r < 93) begin
        do len = 16'($urandom_range(0, 16'hFFFF));
        while (len == MODEM_FRAME_LEN);
        put_header(len);
        put_body(TYPE_MODEM);
        put_body(pick_byte());
      end else begin
        build_good_frame(1'b0);
      end
    end
  endfunction

  // ---------------- sender ----------------

  task automatic feed_byte(input logic [7:0] b, input bit typed, input event_t lit);
    int     gap;
    bit     fired;
    event_t ev;
    if (burst_left == 0) begin
      if ($urandom_range(0, 3) == 0) begin
        burst_left = $urandom_range(60, 200);
        gap        = 0;
      end else begin
        burst_left = $urandom_range(1, 24);
        gap        = $urandom_range(1, 7);
      end
      if (gap != 0) begin
        in_ch.valid   <= 1'b0;
        in_ch.rx_byte <= 8'($urandom_range(0, 255));
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_ch.valid   <= 1'b1;
    in_ch.rx_byte <= b;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    predict_event(b, fired, ev);
    if (typed) begin
      fired = 1'b1;
      ev    = lit;
    end
    if (fired) pending_events = {pending_events, ev};
  endtask

  initial begin : stimulus
    event_t lit;
    int     frame_no;
    int     drain;
    shadow         = PARSE_CLEAR;
    burst_left     = 0;
    hold_req       = 1'b0;
    mismatches     = 0;
    n_checked      = 0;
    n_bytes        = 0;
    n_rx           = 0;
    n_tx           = 0;
    n_modem        = 0;
    n_broken       = 0;
    frame_no       = 0;
    rst_n         <= 1'b0;
    in_ch.valid   <= 1'b0;
    in_ch.rx_byte <= 8'h00;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (DIRECTED_ROWS[i]) begin
      lit            = '0;
      lit.code       = DIRECTED_ROWS[i].code;
      lit.data_value = DIRECTED_ROWS[i].data;
      feed_byte(DIRECTED_ROWS[i].rx_byte, DIRECTED_ROWS[i].typed, lit);
    end

    while (n_bytes < RANDOM_ITEMS) begin
      frame_q.delete();
      if (frame_no == HOLD_FRAME) begin
        // long payload while the sink holds off, so the parser backs up
        hold_req = 1'b1;
        build_rx(60, 1'b1, 1'b1);
        n_rx++;
      end else begin
        if (frame_no == PAUSE_FRAME) begin
          in_ch.valid <= 1'b0;
          do @(posedge clk);
          while (pending_events.size() != 0);
        end
        build_any_frame();
      end
      foreach (frame_q[k]) feed_byte(frame_q[k], 1'b0, '0);
      n_bytes += frame_q.size();
      frame_no++;
    end

    in_ch.valid <= 1'b0;
    drain = 0;
    while (pending_events.size() != 0 && drain < 20000) begin
      @(posedge clk);
      drain++;
    end
    repeat (6) @(posedge clk);
    if (pending_events.size() != 0)
      flag_mismatch("events never delivered", 8'(pending_events.size()), 8'h00);

    $display("covered %0d random link bytes in %0d frames: %0d receive, %0d transmit status,",
             n_bytes, frame_no, n_rx, n_tx);
    $display("  %0d modem status, %0d malformed; %0d events checked, %0d mismatches",
             n_modem, n_broken, n_checked, mismatches);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // ---------------- receiver ----------------

  initial begin : sink_side
    int mode;
    int span;
    out_ch.ready <= 1'b0;
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(20, 120);
      for (int k = 0; k < span; k++) begin
        @(posedge clk);
        if (hold_req) begin
          hold_req = 1'b0;
          out_ch.ready <= 1'b0;
          repeat (HOLD_CYCLES) @(posedge clk);
        end
        case (mode)
          0: out_ch.ready <= 1'b1;
          1: out_ch.ready <= 1'($urandom_range(0, 1));
          2: out_ch.ready <= (k % 5) < 2;
          default: out_ch.ready <= ($urandom_range(0, 4) == 0);
        endcase
      end
    end
  end

  // ---------------- event checker ----------------

  always @(posedge clk) begin : check_events
    event_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_events.size() == 0) begin
        flag_mismatch("unexpected event", 8'(out_ch.event_code), 8'h00);
      end else begin
        want = pending_events.pop_front();
        n_checked++;
        if (out_ch.event_code !== want.code)
          flag_mismatch("event_code", 8'(out_ch.event_code), 8'(want.code));
        if (out_ch.data_value !== want.data_value)
          flag_mismatch("data_value", out_ch.data_value, want.data_value);
        if (out_ch.retry_count !== want.retry_count)
          flag_mismatch("retry_count", out_ch.retry_count, want.retry_count);
        if (out_ch.delivery_status !== want.delivery_status)
          flag_mismatch("delivery_status", out_ch.delivery_status, want.delivery_status);
        if (out_ch.discovery_status !== want.discovery_status)
          flag_mismatch("discovery_status", out_ch.discovery_status, want.discovery_status);
      end
    end
  end

endmodule

// ===== sim.f =====
design/erafp_pkg.sv
design/erafp_ifs.sv
design/erafp_step.sv
design/escaped_radio_api_frame_parser_core.sv
dv/tb.sv
